[hw/rtl/lrpid_pkg.sv]
// shared types and constants of the likelihood-ratio particle identifier
`default_nettype none
package lrpid_pkg;

  localparam int SPECIES_COUNT = 2;

  // shared divider: dividend and divisor widths, iteration counter width
  localparam int DVD_W  = 48;
  localparam int DVS_W  = 33;
  localparam int QCNT_W = 6;

  localparam logic [1:0] FUNC_WRITE    = 2'd0;
  localparam logic [1:0] FUNC_TRAIN    = 2'd1;
  localparam logic [1:0] FUNC_CLASSIFY = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_ZERO  = 2'd2;

  localparam logic [2:0] CFG_CHARGE_THR  = 3'd0;
  localparam logic [2:0] CFG_CLUSTER_THR = 3'd1;
  localparam logic [2:0] CFG_MOM_LOW     = 3'd2;
  localparam logic [2:0] CFG_MOM_HIGH    = 3'd3;
  localparam logic [2:0] CFG_MOM_BW      = 3'd4;
  localparam logic [2:0] CFG_NORM_LIMIT  = 3'd5;
  localparam logic [2:0] CFG_CHARGE_BW   = 3'd6;

  localparam logic [1:0] DIV_MOM  = 2'd0;
  localparam logic [1:0] DIV_CHG  = 2'd1;
  localparam logic [1:0] DIV_FRAC = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] momentum;
    logic        species;
    logic [19:0] plane_charge;
    logic [7:0]  plane_clusters;
    logic        last_plane;
    logic [3:0]  write_momentum_bin;
    logic [6:0]  write_charge_bin;
    logic [15:0] write_count;
  } in_item_t;

  typedef struct packed {
    logic [15:0] electron_likelihood;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       prep;
    logic       wr_item;
    logic       div_start;
    logic [1:0] div_sel;
    logic       take_mbin;
    logic       take_cbin;
    logic       rd_own;
    logic       rd_pion;
    logic       wr_inc;
    logic       take_ce;
    logic       take_cp;
    logic       mul;
    logic       norm;
    logic       mul_pion;
    logic       align;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       last;
    logic       in_range;
    logic       use_plane;
    logic       div_done;
    logic       sum_zero;
    logic       out_free;
    logic       clear_done;
  } sts_t;

endpackage
`default_nettype wire

[hw/rtl/likelihood_ratio_particle_id.sv]
// top level of the electron / pion likelihood-ratio particle identifier
`default_nettype none
// Each input beat is one detector plane of a track. Write and train beats
// never give a result; a classify beat with last_plane set gives one result
// beat and restarts the electron and pion products. After reset the block
// clears its histogram memory, one entry per cycle, and takes no input beat
// until that pass ends; configuration writes are taken at any time. One plane
// occupies the block at a time: no new beat is taken until the block is
// through with the last one. A train or classify plane makes two passes of
// the shared bit-serial divider (momentum bin, then likelihood bin), then,
// if it passes the plane checks, reads its histogram entries (a saturating
// read-modify-write for training); a last classify plane in range adds a
// third divider pass that forms the electron fraction, and a last classify
// plane waits while the previous result is not yet taken. A finished result
// waits in the output register while the next beat is taken.
module likelihood_ratio_particle_id import lrpid_pkg::*; #(
  parameter int MOMENTUM_BINS = 16,
  parameter int CHARGE_BINS   = 100
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  lrpid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrpid_dp #(
    .MOMENTUM_BINS (MOMENTUM_BINS),
    .CHARGE_BINS   (CHARGE_BINS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

[hw/rtl/lrpid_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none
module lrpid_div import lrpid_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [QCNT_W-1:0] cnt;
  logic              busy;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;

  assign trial = {rem, quotient[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == QCNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= diff[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lrpid_ctrl.sv]
// sequencer of the particle identifier
`default_nettype none
module lrpid_ctrl import lrpid_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_MDIV  = 5'd3;
  localparam logic [4:0] S_MWAIT = 5'd4;
  localparam logic [4:0] S_CDIV  = 5'd5;
  localparam logic [4:0] S_CWAIT = 5'd6;
  localparam logic [4:0] S_DECIDE = 5'd7;
  localparam logic [4:0] S_TRD   = 5'd8;
  localparam logic [4:0] S_TINC  = 5'd9;
  localparam logic [4:0] S_RDE   = 5'd10;
  localparam logic [4:0] S_RDP   = 5'd11;
  localparam logic [4:0] S_MULE  = 5'd12;
  localparam logic [4:0] S_NORME = 5'd13;
  localparam logic [4:0] S_MULP  = 5'd14;
  localparam logic [4:0] S_NORMP = 5'd15;
  localparam logic [4:0] S_LAST  = 5'd16;
  localparam logic [4:0] S_FCHK  = 5'd17;
  localparam logic [4:0] S_FWAIT = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.load   = in_valid && in_ready;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        cmd.prep = 1'b1;
        if (sts.func == FUNC_WRITE) begin
          cmd.wr_item = 1'b1;
          state_next  = S_IDLE;
        end else if (sts.func == FUNC_TRAIN || sts.func == FUNC_CLASSIFY) begin
          state_next = S_MDIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MOM;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.div_done) begin
          cmd.take_mbin = 1'b1;
          state_next    = S_CDIV;
        end
      end
      S_CDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CHG;
        state_next    = S_CWAIT;
      end
      S_CWAIT: begin
        if (sts.div_done) begin
          cmd.take_cbin = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.func == FUNC_TRAIN) begin
          state_next = sts.use_plane ? S_TRD : S_IDLE;
        end else begin
          state_next = sts.use_plane ? S_RDE : S_LAST;
        end
      end
      S_TRD: begin
        cmd.rd_own = 1'b1;
        state_next = S_TINC;
      end
      S_TINC: begin
        cmd.rd_own = 1'b1;
        cmd.wr_inc = 1'b1;
        state_next = S_IDLE;
      end
      S_RDE: begin
        state_next = S_RDP;
      end
      S_RDP: begin
        cmd.rd_pion = 1'b1;
        cmd.take_ce = 1'b1;
        state_next  = S_MULE;
      end
      S_MULE: begin
        cmd.take_cp = 1'b1;
        cmd.mul     = 1'b1;
        state_next  = S_NORME;
      end
      S_NORME: begin
        cmd.norm   = 1'b1;
        state_next = S_MULP;
      end
      S_MULP: begin
        cmd.mul      = 1'b1;
        cmd.mul_pion = 1'b1;
        state_next   = S_NORMP;
      end
      S_NORMP: begin
        cmd.norm     = 1'b1;
        cmd.mul_pion = 1'b1;
        state_next   = S_LAST;
      end
      S_LAST: begin
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (!sts.in_range) begin
          state_next = S_OUT;
        end else begin
          cmd.align  = 1'b1;
          state_next = S_FCHK;
        end
      end
      S_FCHK: begin
        if (sts.sum_zero) begin
          state_next = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_FRAC;
          state_next    = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (sts.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_DISP)
    else $error("accepted beat not dispatched");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result overwritten before taken");
  a_mom_to_charge: assert property (@(posedge clk) disable iff (rst)
    (state == S_MWAIT && sts.div_done) |=> state == S_CDIV)
    else $error("charge division not started after momentum bin");
`endif

endmodule
`default_nettype wire

[hw/rtl/lrpid_dp.sv]
// datapath: config registers, histogram memory, divider, products, result
`default_nettype none
module lrpid_dp import lrpid_pkg::*; #(
  parameter int MOMENTUM_BINS = 16,
  parameter int CHARGE_BINS   = 100
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire in_item_t   in_data,
  input  wire logic       cfg_valid,
  input  wire logic [2:0] cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic       out_ready,
  output logic            out_valid,
  output out_item_t       out_data,
  input  wire cmd_t       cmd,
  output sts_t            sts
);

  localparam int MB_W   = (MOMENTUM_BINS > 1) ? $clog2(MOMENTUM_BINS) : 1;
  localparam int CB_W   = (CHARGE_BINS > 1) ? $clog2(CHARGE_BINS) : 1;
  localparam int DEPTH  = MOMENTUM_BINS * SPECIES_COUNT * CHARGE_BINS;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration
  logic [19:0] charge_thr;
  logic [7:0]  cluster_thr;
  logic [15:0] mom_low, mom_high, mom_bw;
  logic [19:0] norm_limit;
  logic [15:0] charge_bw;

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_thr  <= 20'd0;
      cluster_thr <= 8'd10;
      mom_low     <= 16'd0;
      mom_high    <= 16'd65535;
      mom_bw      <= 16'd4096;
      norm_limit  <= 20'd500;
      charge_bw   <= 16'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHARGE_THR:  charge_thr  <= cfg_data;
        CFG_CLUSTER_THR: cluster_thr <= cfg_data[7:0];
        CFG_MOM_LOW:     mom_low     <= cfg_data[15:0];
        CFG_MOM_HIGH:    mom_high    <= cfg_data[15:0];
        CFG_MOM_BW:      mom_bw      <= cfg_data[15:0];
        CFG_NORM_LIMIT:  norm_limit  <= cfg_data;
        CFG_CHARGE_BW:   charge_bw   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  in_item_t item;
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
  end

  // plane checks and bin divisors
  logic        in_range, pre_ok, plane_ok;
  logic [15:0] mdiff;
  logic [27:0] lim_prod;
  logic [23:0] cdivisor;
  logic [15:0] mom_bw_eff, charge_bw_eff;

  assign mom_bw_eff    = (mom_bw == 16'd0) ? 16'd1 : mom_bw;
  assign charge_bw_eff = (charge_bw == 16'd0) ? 16'd1 : charge_bw;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      in_range <= (item.momentum >= mom_low) && (item.momentum <= mom_high);
      mdiff    <= item.momentum - mom_low;
      lim_prod <= norm_limit * item.plane_clusters;
      cdivisor <= item.plane_clusters * charge_bw_eff;
      pre_ok   <= (item.plane_charge > charge_thr) && (item.plane_clusters > cluster_thr);
    end
  end

  // shared divider
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic [31:0]      a_al, b_al;
  logic [32:0]      sum;

  always_comb begin
    case (cmd.div_sel)
      DIV_MOM: begin
        dvd = DVD_W'(mdiff);
        dvs = DVS_W'(mom_bw_eff);
      end
      DIV_CHG: begin
        dvd = DVD_W'(item.plane_charge);
        dvs = DVS_W'(cdivisor);
      end
      default: begin
        dvd = {a_al, 16'd0};
        dvs = sum;
      end
    endcase
  end

  lrpid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  logic [MB_W-1:0] mbin;
  logic [CB_W-1:0] cbin;

  always_ff @(posedge clk) begin
    if (cmd.take_mbin) begin
      if (div_q > DVD_W'(MOMENTUM_BINS - 1)) mbin <= MB_W'(MOMENTUM_BINS - 1);
      else mbin <= div_q[MB_W-1:0];
    end
    if (cmd.take_cbin) begin
      plane_ok <= pre_ok && ({8'd0, item.plane_charge} < lim_prod) &&
                  (div_q < DVD_W'(CHARGE_BINS));
      cbin     <= div_q[CB_W-1:0];
    end
  end

  // histogram memory
  logic [15:0]       mem [DEPTH];
  logic [15:0]       rdata;
  logic [ADDR_W-1:0] clr_cnt, raddr, waddr, item_addr;
  logic              rd_sp, we, item_ok;
  logic [15:0]       wdata;

  assign rd_sp     = cmd.rd_own ? item.species : cmd.rd_pion;
  assign raddr     = ADDR_W'((32'(mbin) * SPECIES_COUNT + 32'(rd_sp)) * CHARGE_BINS
                             + 32'(cbin));
  assign item_addr = ADDR_W'((32'(item.write_momentum_bin) * SPECIES_COUNT
                             + 32'(item.species)) * CHARGE_BINS
                             + 32'(item.write_charge_bin));
  assign item_ok   = (32'(item.write_momentum_bin) < MOMENTUM_BINS) &&
                     (32'(item.write_charge_bin) < CHARGE_BINS);

  always_comb begin
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = 16'd0;
    end else if (cmd.wr_item) begin
      we    = item_ok;
      waddr = item_addr;
      wdata = item.write_count;
    end else begin
      // saturating bin count
      we    = cmd.wr_inc && (rdata != 16'hFFFF);
      waddr = raddr;
      wdata = rdata + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
  end

  // running products
  logic [31:0] mant_e, mant_p;
  logic [7:0]  exp_e, exp_p;
  logic [15:0] count_e, count_p;
  logic [47:0] prod;
  logic [31:0] mant_x;
  logic [15:0] count_x;
  logic [7:0]  exp_x;
  logic [4:0]  sh;
  logic [8:0]  exp_sum;
  logic [31:0] norm_mant;
  logic [7:0]  norm_exp;

  assign mant_x  = cmd.mul_pion ? mant_p : mant_e;
  assign count_x = cmd.mul_pion ? count_p : count_e;
  assign exp_x   = cmd.mul_pion ? exp_p : exp_e;

  always_comb begin
    sh = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (prod[32+i]) sh = 5'(i + 1);
    end
    exp_sum = {1'b0, exp_x} + {4'd0, sh};
    if (exp_sum > 9'd255) begin
      norm_mant = 32'hFFFF_FFFF;
      norm_exp  = 8'd255;
    end else begin
      norm_mant = 32'(prod >> sh);
      norm_exp  = exp_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_ce) count_e <= rdata;
    if (cmd.take_cp) count_p <= rdata;
    if (cmd.mul) prod <= mant_x * count_x;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      mant_e <= 32'd1;
      exp_e  <= 8'd0;
      mant_p <= 32'd1;
      exp_p  <= 8'd0;
    end else if (cmd.norm && count_x != 16'd0) begin
      if (cmd.mul_pion) begin
        mant_p <= norm_mant;
        exp_p  <= norm_exp;
      end else begin
        mant_e <= norm_mant;
        exp_e  <= norm_exp;
      end
    end
  end

  // bring both products to the larger exponent
  always_ff @(posedge clk) begin
    if (cmd.align) begin
      if (exp_e >= exp_p) begin
        a_al <= mant_e;
        b_al <= mant_p >> (exp_e - exp_p);
        sum  <= {1'b0, mant_e} + {1'b0, mant_p >> (exp_e - exp_p)};
      end else begin
        a_al <= mant_e >> (exp_p - exp_e);
        b_al <= mant_p;
        sum  <= {1'b0, mant_e >> (exp_p - exp_e)} + {1'b0, mant_p};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!in_range) begin
        out_data.electron_likelihood <= 16'd0;
        out_data.status              <= STATUS_RANGE;
      end else if (sum == 33'd0) begin
        out_data.electron_likelihood <= 16'd0;
        out_data.status              <= STATUS_ZERO;
      end else begin
        out_data.electron_likelihood <= (div_q > DVD_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
        out_data.status              <= STATUS_OK;
      end
    end
  end

  assign sts.func       = item.func;
  assign sts.last       = item.last_plane;
  assign sts.in_range   = in_range;
  assign sts.use_plane  = in_range && plane_ok;
  assign sts.div_done   = div_done;
  assign sts.sum_zero   = (sum == 33'd0) || (b_al == 32'd0 && a_al == 32'd0);
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.clear_done = (clr_cnt == ADDR_W'(DEPTH - 1));

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// testbench for the electron / pion likelihood-ratio particle identifier
`timescale 1ns / 100ps
module testbench;
  import lrpid_pkg::*;

  localparam int MBINS = 16;
  localparam int CBINS = 100;
  localparam int SETTLE = 250;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  likelihood_ratio_particle_id u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers and memory
  logic [19:0] thr_charge;
  logic [7:0]  thr_clusters;
  logic [15:0] mom_lo, mom_hi, mom_bw, cbin_bw;
  logic [19:0] norm_limit;
  logic [15:0] hist [MBINS*SPECIES_COUNT*CBINS];
  logic [31:0] el_mant, pi_mant;
  int          el_expo, pi_expo;

  out_item_t likelihoods_due[$];
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  range_results = 0;
  bit  quiet = 0;
  longint cycles = 0;

  function automatic int hist_addr(int mb, int sp, int cb);
    return (mb * SPECIES_COUNT + sp) * CBINS + cb;
  endfunction

  function automatic bit find_mbin(logic [15:0] m, output int b);
    int w;
    w = (mom_bw == 0) ? 1 : mom_bw;
    b = 0;
    if (m < mom_lo || m > mom_hi) return 0;
    b = (m - mom_lo) / w;
    if (b > MBINS - 1) b = MBINS - 1;
    return 1;
  endfunction

  function automatic bit find_cbin(logic [19:0] q, logic [7:0] n, output int b);
    longint unsigned w, r;
    w = (cbin_bw == 0) ? 1 : cbin_bw;
    b = 0;
    if (q <= thr_charge || n <= thr_clusters) return 0;
    if (longint'(q) >= longint'(norm_limit) * n) return 0;
    r = longint'(q) / (longint'(n) * w);
    if (r >= CBINS) return 0;
    b = int'(r);
    return 1;
  endfunction

  task automatic scale_product(inout logic [31:0] mant, inout int expo, input int cnt);
    longint unsigned p;
    p = longint'(mant) * cnt;
    while (p > 64'hFFFF_FFFF) begin
      if (expo >= 255) begin
        p = 64'hFFFF_FFFF;
        break;
      end
      p = p >> 1;
      expo++;
    end
    mant = p[31:0];
  endtask

  task automatic restart_products();
    el_mant = 1; el_expo = 0; pi_mant = 1; pi_expo = 0;
  endtask

  // works out what one accepted plane does to the shadow state
  task automatic predict_plane(in_item_t it);
    int mb, cb, ce, cp, d;
    bit ok;
    longint unsigned a, b, total, frac;
    out_item_t r;
    if (it.func == FUNC_WRITE) begin
      if (it.write_charge_bin < CBINS && it.write_momentum_bin < MBINS)
        hist[hist_addr(it.write_momentum_bin, it.species, it.write_charge_bin)]
          = it.write_count;
      return;
    end
    if (it.func != FUNC_TRAIN && it.func != FUNC_CLASSIFY) return;
    ok = find_mbin(it.momentum, mb);
    if (it.func == FUNC_TRAIN) begin
      if (ok && find_cbin(it.plane_charge, it.plane_clusters, cb))
        if (hist[hist_addr(mb, it.species, cb)] != 16'hFFFF)
          hist[hist_addr(mb, it.species, cb)]++;
      return;
    end
    if (ok && find_cbin(it.plane_charge, it.plane_clusters, cb)) begin
      ce = hist[hist_addr(mb, 0, cb)];
      cp = hist[hist_addr(mb, 1, cb)];
      if (ce != 0) scale_product(el_mant, el_expo, ce);
      if (cp != 0) scale_product(pi_mant, pi_expo, cp);
    end
    if (!it.last_plane) return;
    r = '0;
    if (!ok) begin
      r.status = STATUS_RANGE;
    end else begin
      a = el_mant;
      b = pi_mant;
      if (el_expo >= pi_expo) begin
        d = el_expo - pi_expo;
        b = (d >= 64) ? 0 : (b >> d);
      end else begin
        d = pi_expo - el_expo;
        a = (d >= 64) ? 0 : (a >> d);
      end
      total = a + b;
      if (total == 0) begin
        r.status = STATUS_ZERO;
      end else begin
        frac = (a << 16) / total;
        if (frac > 65535) frac = 65535;
        r.electron_likelihood = frac[15:0];
        r.status = STATUS_OK;
      end
    end
    likelihoods_due.push_back(r);
    restart_products();
  endtask

  task automatic send_plane(in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_plane(it);
    items_sent++;
  endtask

  // waits until every result is back and the block has finished any plane
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (likelihoods_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CHARGE_THR:  thr_charge = val;
      CFG_CLUSTER_THR: thr_clusters = val[7:0];
      CFG_MOM_LOW:     mom_lo = val[15:0];
      CFG_MOM_HIGH:    mom_hi = val[15:0];
      CFG_MOM_BW:      mom_bw = val[15:0];
      CFG_NORM_LIMIT:  norm_limit = val;
      CFG_CHARGE_BW:   cbin_bw = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_setting(logic [19:0] qt, logic [7:0] nt, logic [15:0] lo,
                              logic [15:0] hi, logic [15:0] mw, logic [19:0] nl,
                              logic [15:0] cw);
    drain();
    write_reg(CFG_CHARGE_THR, qt);
    write_reg(CFG_CLUSTER_THR, {12'd0, nt});
    write_reg(CFG_MOM_LOW, {4'd0, lo});
    write_reg(CFG_MOM_HIGH, {4'd0, hi});
    write_reg(CFG_MOM_BW, {4'd0, mw});
    write_reg(CFG_NORM_LIMIT, nl);
    write_reg(CFG_CHARGE_BW, {4'd0, cw});
  endtask

  function automatic in_item_t make_plane(logic [1:0] f, logic [15:0] m, logic sp,
                                          logic [19:0] q, logic [7:0] n, logic lp);
    in_item_t it;
    it = '0;
    it.func = f; it.momentum = m; it.species = sp;
    it.plane_charge = q; it.plane_clusters = n; it.last_plane = lp;
    return it;
  endfunction

  function automatic in_item_t make_write(logic [3:0] mb, logic sp, logic [6:0] cb,
                                          logic [15:0] cnt);
    in_item_t it;
    it = '0;
    it.func = FUNC_WRITE; it.species = sp;
    it.write_momentum_bin = mb; it.write_charge_bin = cb; it.write_count = cnt;
    return it;
  endfunction

  // a plane aimed at a usable likelihood bin under the current setting
  function automatic in_item_t aimed_plane(logic [1:0] f, logic [15:0] m, logic lp);
    in_item_t it;
    int n, w;
    longint q;
    n = (thr_clusters >= 250) ? 255 : $urandom_range(thr_clusters + 1,
                                                      thr_clusters + 5 + ($urandom % 40));
    if (n > 255) n = 255;
    w = (cbin_bw == 0) ? 1 : cbin_bw;
    q = longint'(n) * w * $urandom_range(0, CBINS - 1) + $urandom_range(0, n * w - 1);
    if ($urandom % 8 == 0) q = $urandom;
    it = make_plane(f, m, 1'($urandom), q[19:0], n[7:0], lp);
    it.write_momentum_bin = 4'($urandom);
    it.write_charge_bin = 7'($urandom);
    it.write_count = 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] pick_momentum();
    if ($urandom % 10 == 0 || mom_lo > mom_hi) return 16'($urandom);
    return 16'($urandom_range(mom_lo, mom_hi));
  endfunction

  task automatic random_traffic(int n_items);
    in_item_t it;
    int stop, planes, kind;
    logic [15:0] m;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      kind = $urandom % 10;
      if ($urandom % 20 == 0) quiet = ~quiet;
      if (kind == 0) begin
        it = in_item_t'(76'({$urandom, $urandom, $urandom}));
        send_plane(it);
      end else if (kind == 1) begin
        send_plane(make_write(4'($urandom), 1'($urandom), 7'($urandom_range(0, 127)),
                              16'($urandom)));
      end else if (kind <= 4) begin
        m = pick_momentum();
        repeat ($urandom_range(1, 6))
          send_plane(aimed_plane(FUNC_TRAIN, m, 1'($urandom)));
      end else begin
        m = pick_momentum();
        planes = $urandom_range(1, 6);
        for (int p = 1; p <= planes; p++) begin
          if ($urandom % 16 == 0) m = pick_momentum();
          send_plane(aimed_plane(FUNC_CLASSIFY, m, p == planes));
        end
      end
    end
    quiet = 0;
  endtask

  task automatic test_empty_store();
    in_item_t it;
    send_plane(make_plane(FUNC_CLASSIFY, 16'd0, 1'b0, 20'd300, 8'd20, 1'b1));
    send_plane(make_plane(FUNC_CLASSIFY, 16'hFFFF, 1'b1, 20'hFFFFF, 8'hFF, 1'b1));
    it = make_write(4'd3, 1'b0, 7'd100, 16'd7);
    send_plane(it);
    it = make_write(4'd15, 1'b1, 7'd127, 16'hFFFF);
    send_plane(it);
    it = in_item_t'('1);
    send_plane(it);
  endtask

  task automatic test_bins_and_products();
    send_plane(make_write(4'd0, 1'b0, 7'd10, 16'hFFFF));
    send_plane(make_write(4'd0, 1'b1, 7'd10, 16'd1));
    send_plane(make_write(4'd15, 1'b0, 7'd99, 16'd3));
    send_plane(make_write(4'd15, 1'b1, 7'd99, 16'd0));
    // saturating count
    send_plane(make_plane(FUNC_TRAIN, 16'd100, 1'b0, 20'd1000, 8'd20, 1'b1));
    send_plane(make_plane(FUNC_TRAIN, 16'd100, 1'b1, 20'd1000, 8'd20, 1'b0));
    // momentum at the top of the range lands in the last bin
    send_plane(make_plane(FUNC_CLASSIFY, 16'hFFFF, 1'b0, 20'd9950, 8'd20, 1'b1));
    // exponent climbs to its ceiling, pion side falls away entirely
    for (int p = 0; p < 18; p++)
      send_plane(make_plane(FUNC_CLASSIFY, 16'd5, 1'b0, 20'd1000, 8'd20, p == 17));
  endtask

  task automatic test_range_edges();
    load_setting(20'd0, 8'd0, 16'd1000, 16'd2000, 16'd0, 20'hFFFFF, 16'd0);
    send_plane(make_plane(FUNC_TRAIN, 16'd1000, 1'b0, 20'd1, 8'd1, 1'b0));
    send_plane(make_plane(FUNC_CLASSIFY, 16'd999, 1'b0, 20'd1, 8'd1, 1'b1));
    send_plane(make_plane(FUNC_CLASSIFY, 16'd2001, 1'b0, 20'd1, 8'd1, 1'b1));
    send_plane(make_plane(FUNC_CLASSIFY, 16'd2000, 1'b0, 20'd1, 8'd1, 1'b1));
    send_plane(make_plane(FUNC_CLASSIFY, 16'd1000, 1'b0, 20'd1, 8'd1, 1'b1));
    load_setting(20'hFFFFF, 8'hFF, 16'hFFFF, 16'd0, 16'hFFFF, 20'd1, 16'hFFFF);
    send_plane(make_plane(FUNC_TRAIN, 16'd0, 1'b1, 20'hFFFFF, 8'hFF, 1'b0));
    send_plane(make_plane(FUNC_CLASSIFY, 16'hFFFF, 1'b0, 20'hFFFFF, 8'hFF, 1'b1));
  endtask

  task automatic test_setting_sweep();
    load_setting(20'd0, 8'd10, 16'd0, 16'hFFFF, 16'd4096, 20'd500, 16'd5);
    random_traffic(450);
    load_setting(20'd0, 8'd0, 16'd0, 16'hFFFF, 16'd1, 20'd30, 16'd1);
    random_traffic(200);
    load_setting(20'($urandom_range(0, 2000)), 8'd3, 16'd500, 16'd40000, 16'hFFFF,
                 20'hFFFFF, 16'd0);
    random_traffic(200);
    load_setting(20'd50, 8'd254, 16'd100, 16'd60000, 16'd3000, 20'd700, 16'd7);
    random_traffic(100);
    for (int s = 0; s < 3; s++) begin
      load_setting(20'($urandom_range(0, 500)), 8'($urandom_range(0, 30)),
                   16'($urandom_range(0, 8000)), 16'($urandom_range(8000, 65535)),
                   16'($urandom_range(1, 5000)), 20'($urandom_range(50, 2000)),
                   16'($urandom_range(1, 20)));
      random_traffic(220);
    end
  endtask

  // result checking and receiver stalls
  int hold = 0;
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (likelihoods_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d", $time,
                 out_data.electron_likelihood, out_data.status);
        errors++;
      end else begin
        exp_r = likelihoods_due.pop_front();
        if (exp_r.status == STATUS_RANGE) range_results++;
        if (exp_r.status != out_data.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_data.status);
          errors++;
        end
        if (exp_r.electron_likelihood != out_data.electron_likelihood) begin
          $display("%0t: electron_likelihood expected %0d actual %0d", $time,
                   exp_r.electron_likelihood, out_data.electron_likelihood);
          errors++;
        end
      end
      hold = quiet ? 0 : $urandom_range(0, 15);
    end
    if (hold > 0) begin
      hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               likelihoods_due.size());
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    thr_charge = 0; thr_clusters = 10; mom_lo = 0; mom_hi = 16'hFFFF;
    mom_bw = 4096; norm_limit = 500; cbin_bw = 5;
    foreach (hist[i]) hist[i] = '0;
    restart_products();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_bins_and_products();
    test_range_edges();
    test_setting_sweep();
    drain();
    $display("sent %0d planes under 10 register settings, %0d likelihoods checked",
             items_sent, results_seen);
    $display("%0d of them out-of-range answers", range_results);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
